FILE: rtl/core/sdik_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdik_pkg
// Types, constants and the arctangent table for swerve inverse kinematics.
// ----------------------------------------------------------------------------
package sdik_pkg;

    localparam int VelW     = 16;
    localparam int BaseW    = 12;
    localparam int SpeedW   = 18;
    localparam int HeadW    = 15;
    localparam int CompW    = 29;   // wheel component, Q.10 mm/s
    localparam int CordW    = 32;   // CORDIC x/y datapath, grows by gain
    localparam int AtanLen  = 24;

    localparam logic [29:0] InvGainQ30 = 30'd652032874;

    localparam logic [0:0] RegHalfBaseX = 1'b0;
    localparam logic [0:0] RegHalfBaseY = 1'b1;

    typedef logic signed [CordW-1:0] t_cord;

    function automatic logic [31:0] atan_turns(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sdik_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
interface sdik_cmd_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   vel_x;
    logic signed [15:0]   vel_y;
    logic signed [15:0]   yaw_rate;
    modport source (output valid, vel_x, vel_y, yaw_rate, input ready);
    modport sink   (input valid, vel_x, vel_y, yaw_rate, output ready);
endinterface

interface sdik_res_if;
    logic        valid;
    logic        ready;
    logic [17:0] fl_speed;
    logic [14:0] fl_heading;
    logic [17:0] fr_speed;
    logic [14:0] fr_heading;
    logic [17:0] rl_speed;
    logic [14:0] rl_heading;
    logic [17:0] rr_speed;
    logic [14:0] rr_heading;
    modport source (output valid, fl_speed, fl_heading, fr_speed, fr_heading,
                    rl_speed, rl_heading, rr_speed, rr_heading, input ready);
    modport sink   (input valid, fl_speed, fl_heading, fr_speed, fr_heading,
                    rl_speed, rl_heading, rr_speed, rr_heading, output ready);
endinterface

interface sdik_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [11:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sdik_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdik_cordic
// Pipelined vectoring CORDIC for one wheel: magnitude and heading.
// ----------------------------------------------------------------------------
module sdik_cordic #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [sdik_pkg::CompW-1:0] i_x,
    input  wire logic signed [sdik_pkg::CompW-1:0] i_y,
    output logic [sdik_pkg::SpeedW-1:0]        o_speed,
    output logic [sdik_pkg::HeadW-1:0]         o_heading
);
    import sdik_pkg::*;

    localparam int Steps    = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;
    localparam int FullTurn = 360 * (2 ** ANGLE_FRAC_BITS);
    localparam int FullW    = $clog2(FullTurn + 1);
    localparam int ProdW    = 32 + FullW;

    // stage arrays: entry 0 is the pre-rotated input, k after step k-1
    t_cord       r_x [Steps+1];
    t_cord       r_y [Steps+1];
    logic [31:0] r_z [Steps+1];
    logic        r_zero [Steps+1];

    // front: zero test and half-plane fold
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -t_cord'(i_x);
                r_y[0] <= -t_cord'(i_y);
                r_z[0] <= 32'h8000_0000;
            end else begin
                r_x[0] <= t_cord'(i_x);
                r_y[0] <= t_cord'(i_y);
                r_z[0] <= 32'd0;
            end
        end
    end

    for (genvar k = 0; k < Steps; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[k+1] <= r_zero[k];
                if (r_y[k] > 0) begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_turns(k);
                end else begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_turns(k);
                end
            end
        end
    end

    // scale stage: gain correction and angle conversion, one multiply each
    logic [61:0]      r_mag;
    logic [ProdW-1:0] r_hprod;
    logic             r_zero_s;
    logic [CordW-2:0] w_xpos;
    assign w_xpos = r_x[Steps][CordW-1] ? '0 : r_x[Steps][CordW-2:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero_s <= r_zero[Steps];
            r_mag    <= 62'(w_xpos) * 62'(InvGainQ30);
            r_hprod  <= ProdW'(r_z[Steps]) * ProdW'(FullTurn);
        end
    end

    logic [61:0]      w_mag_rnd;
    logic [ProdW-1:0] w_h_rnd;
    logic [FullW-1:0] w_h;
    assign w_mag_rnd = r_mag + (62'd1 << 39);
    assign w_h_rnd   = r_hprod + (ProdW'(1) << 31);
    assign w_h       = w_h_rnd[ProdW-1:32];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero_s) begin
                o_speed   <= '0;
                o_heading <= '0;
            end else begin
                o_speed   <= w_mag_rnd[40 +: SpeedW];
                o_heading <= (w_h >= FullW'(FullTurn)) ? '0 : HeadW'(w_h);
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/sdik_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdik_front
// Yaw products and the four wheel velocity components, two register stages.
// ----------------------------------------------------------------------------
module sdik_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [15:0]                i_vel_x,
    input  wire logic signed [15:0]                i_vel_y,
    input  wire logic signed [15:0]                i_yaw_rate,
    input  wire logic [11:0]                       i_hx,
    input  wire logic [11:0]                       i_hy,
    output logic signed [sdik_pkg::CompW-1:0]      o_x_minus,
    output logic signed [sdik_pkg::CompW-1:0]      o_x_plus,
    output logic signed [sdik_pkg::CompW-1:0]      o_y_plus,
    output logic signed [sdik_pkg::CompW-1:0]      o_y_minus
);
    import sdik_pkg::*;

    logic signed [28:0] r_wx, r_wy, r_vx, r_vy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= 29'(i_yaw_rate) * 29'($signed({1'b0, i_hx}));
            r_wy <= 29'(i_yaw_rate) * 29'($signed({1'b0, i_hy}));
            r_vx <= 29'($signed({i_vel_x, 10'd0}));
            r_vy <= 29'($signed({i_vel_y, 10'd0}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x_minus <= r_vx - r_wy;
            o_x_plus  <= r_vx + r_wy;
            o_y_plus  <= r_vy + r_wx;
            o_y_minus <= r_vy - r_wx;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/swerve_drive_inverse_kinematics_top.sv
`default_nettype none
// Throughput: one command per cycle; the pipeline advances whenever the
// output register is empty or being taken, so a stall freezes every stage.
// Reset: clears valid bits; half bases return to 200 mm each.
// ----------------------------------------------------------------------------
// swerve_drive_inverse_kinematics_top
// Four-wheel swerve inverse kinematics with pipelined CORDIC per wheel.
// ----------------------------------------------------------------------------
module swerve_drive_inverse_kinematics_top #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sdik_cmd_if.sink    i_cmd,
    sdik_cfg_if.sink    i_cfg,
    sdik_res_if.source  o_res
);
    import sdik_pkg::*;

    localparam int Steps = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;
    localparam int Lat   = Steps + 5;

    logic [11:0] r_hx, r_hy;
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hx <= 12'd200;
            r_hy <= 12'd200;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                RegHalfBaseX: r_hx <= i_cfg.data;
                RegHalfBaseY: r_hy <= i_cfg.data;
                default: ;
            endcase
        end
    end

    logic w_en;
    logic [Lat-1:0] r_vld;
    assign w_en        = !r_vld[Lat-1] || o_res.ready;
    assign i_cmd.ready = w_en;
    assign o_res.valid = r_vld[Lat-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Lat-2:0], i_cmd.valid};
        end
    end

    logic signed [CompW-1:0] w_xm, w_xp, w_yp, w_ym;

    sdik_front u_front (
        .i_clk(i_clk), .i_en(w_en),
        .i_vel_x(i_cmd.vel_x), .i_vel_y(i_cmd.vel_y), .i_yaw_rate(i_cmd.yaw_rate),
        .i_hx(r_hx), .i_hy(r_hy),
        .o_x_minus(w_xm), .o_x_plus(w_xp), .o_y_plus(w_yp), .o_y_minus(w_ym)
    );

    sdik_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_fl (
        .i_clk(i_clk), .i_en(w_en), .i_x(w_xm), .i_y(w_yp),
        .o_speed(o_res.fl_speed), .o_heading(o_res.fl_heading));
    sdik_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_fr (
        .i_clk(i_clk), .i_en(w_en), .i_x(w_xp), .i_y(w_yp),
        .o_speed(o_res.fr_speed), .o_heading(o_res.fr_heading));
    sdik_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_rl (
        .i_clk(i_clk), .i_en(w_en), .i_x(w_xm), .i_y(w_ym),
        .o_speed(o_res.rl_speed), .o_heading(o_res.rl_heading));
    sdik_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_rr (
        .i_clk(i_clk), .i_en(w_en), .i_x(w_xp), .i_y(w_ym),
        .o_speed(o_res.rr_speed), .o_heading(o_res.rr_heading));

`ifndef ASSERT_OFF
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.fl_speed))
        else $error("result changed during stall");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_cmd.ready)
        else $error("input stalled with empty output");
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.fl_heading < 15'(360 * (2 ** ANGLE_FRAC_BITS)))
        else $error("heading out of range");
`endif

endmodule
`default_nettype wire
